>>> hw/rtl/mis_pkg.sv
// mis_pkg: shared constants for the multidimensional index stepper
// command codes, register widths, register reset values and default parameters
// no dependencies
`default_nettype none

package mis_pkg;

    // default configuration of the stepper
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_EXTENT_BITS = 16;

    // fixed field widths
    localparam int CMD_W      = 3;
    localparam int NDIMS_W    = 3;
    localparam int APB_DATA_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_NEXTND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PREV   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

    // register map index of num_dims; extents follow at 1..MAX_DIMS
    localparam int REG_NUM_DIMS = 0;

    // register reset values
    localparam logic [NDIMS_W-1:0] NUM_DIMS_RST = 3'd1;

endpackage : mis_pkg

`default_nettype wire

>>> hw/rtl/mis_if.sv
// mis_req_if / mis_rsp_if: valid/ready channels of the index stepper
// depends on mis_pkg for the command width and the default parameters
`default_nettype none

interface mis_req_if
    import mis_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DIGIT_W  = DEF_EXTENT_BITS + 1
);
    typedef logic signed [DIGIT_W-1:0] digit_t;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    digit_t           load_value [MAX_DIMS];

    modport source (output valid, output command, output load_value, input ready);
    modport sink   (input valid, input command, input load_value, output ready);
endinterface : mis_req_if

interface mis_rsp_if
    import mis_pkg::*;
#(
    parameter int MAX_DIMS = DEF_MAX_DIMS,
    parameter int DIGIT_W  = DEF_EXTENT_BITS + 1
);
    typedef logic signed [DIGIT_W-1:0] digit_t;

    logic   valid;
    logic   ready;
    digit_t index [MAX_DIMS];
    logic   advanced;
    logic   in_bounds;
    logic   in_bounds_ext;

    modport source (
        output valid, output index, output advanced, output in_bounds,
        output in_bounds_ext, input ready
    );
    modport sink (
        input valid, input index, input advanced, input in_bounds,
        input in_bounds_ext, output ready
    );
endinterface : mis_rsp_if

`default_nettype wire

>>> hw/rtl/multidim_index_stepper.sv
// multidim_index_stepper: mixed-radix index register with odometer, nondecreasing
// and backward stepping plus bounds checks; apb-style configuration port
// depends on mis_pkg, mis_req_if and mis_rsp_if
`default_nettype none

// usage
//   req channel: one beat carries a command (load, next, next nondecreasing,
//     previous, query) and MAX_DIMS load digits, used only by load
//   rsp channel: one beat per request with the index after the command, the
//     advanced flag and the two bounds checks
//   apb port: num_dims at byte 0, extent_k at byte 4*(k+1); write only while
//     no request is in flight; reads return the register value
// path: a request beat lands in the request register, the step logic runs
//   from there into the result register, and the result register drives
//   rsp.valid and the result beat
// throughput: one beat per cycle while results are taken; the index register
//   is updated by the same combinational step logic that fills the result
//   register, so a request can use the index left by the request just before it
// stall: a full result register that is not taken holds the request register,
//   and the request register then holds off req.ready; with both full the
//   block absorbs no more beats
// reset: index digits are cleared, num_dims goes to 1 and every extent to 1;
//   both registers of the pipe come up empty

module multidim_index_stepper
    import mis_pkg::*;
#(
    parameter int MAX_DIMS    = DEF_MAX_DIMS,
    parameter int EXTENT_BITS = DEF_EXTENT_BITS
)(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [$clog2((MAX_DIMS+1)*4)-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0]                 pwdata,
    output logic      [APB_DATA_W-1:0]                 prdata,
    output logic                                       pready,
    // channels
    mis_req_if.sink                                    req,
    mis_rsp_if.source                                  rsp
);

    localparam int DIGIT_W = EXTENT_BITS + 1;
    // one spare bit so extent and extent - 1 compare as signed against digits
    localparam int CALC_W  = EXTENT_BITS + 2;
    localparam int CNT_W   = $clog2(MAX_DIMS + 1);
    localparam int ADDR_W  = $clog2((MAX_DIMS + 1) * 4);
    localparam int RIDX_W  = ADDR_W - 2;

    typedef logic [MAX_DIMS-1:0][DIGIT_W-1:0] digits_t;
    typedef logic signed [CALC_W-1:0]         calc_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [NDIMS_W-1:0]     num_dims_reg;
    logic [EXTENT_BITS-1:0] ext_reg [MAX_DIMS];
    logic [RIDX_W-1:0]      reg_idx;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= NUM_DIMS_RST;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                ext_reg[k] <= EXTENT_BITS'(1);
            end
        end
        else if (cfg_wr)
        begin
            if (reg_idx == RIDX_W'(REG_NUM_DIMS))
            begin
                num_dims_reg <= pwdata[NDIMS_W-1:0];
            end
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                if (reg_idx == RIDX_W'(k + 1))
                begin
                    ext_reg[k] <= pwdata[EXTENT_BITS-1:0];
                end
            end
        end
    end

    // register read mux; addresses past the map read zero
    always_comb
    begin
        prdata = '0;
        if (reg_idx == RIDX_W'(REG_NUM_DIMS))
        begin
            prdata = APB_DATA_W'(num_dims_reg);
        end
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (reg_idx == RIDX_W'(k + 1))
            begin
                prdata = APB_DATA_W'(ext_reg[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // request register and pipe handshake
    // ------------------------------------------------------------------
    logic             req_valid_reg;
    logic [CMD_W-1:0] req_cmd_reg;
    digits_t          req_ld_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             step_fire;

    // result register can take a new beat when empty or being drained
    assign out_free  = !out_valid_reg || rsp.ready;
    assign step_fire = req_valid_reg && out_free;
    assign req.ready = !req_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_cmd_reg <= req.command;
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                req_ld_reg[k] <= req.load_value[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // step logic
    // ------------------------------------------------------------------
    digits_t               idx_reg;
    digits_t               idx_next;
    logic [CNT_W-1:0]      used;
    logic [MAX_DIMS-1:0]   used_mask;
    logic [MAX_DIMS-1:0]   last_mask;
    logic [MAX_DIMS-1:0]   can_inc;
    logic [MAX_DIMS-1:0]   can_dec;
    logic [MAX_DIMS-1:0]   piv_inc;
    logic [MAX_DIMS-1:0]   piv_dec;
    logic [MAX_DIMS-1:0]   aft_inc;
    logic [MAX_DIMS-1:0]   aft_dec;
    calc_t                 dig  [MAX_DIMS];
    calc_t                 ext  [MAX_DIMS];
    calc_t                 lim  [MAX_DIMS];
    calc_t                 nxt  [MAX_DIMS];
    calc_t                 piv_val;
    logic                  have_dims;
    logic                  adv_next;
    logic                  ok_next;
    logic                  ok_ext_next;

    // highest set bit of a mask as a one-hot vector (fastest digit wins)
    function automatic logic [MAX_DIMS-1:0] top_onehot(input logic [MAX_DIMS-1:0] m);
        logic [MAX_DIMS-1:0] r;
        logic                seen;
        r    = '0;
        seen = 1'b0;
        for (int k = MAX_DIMS - 1; k >= 0; k--)
        begin
            r[k] = m[k] && !seen;
            seen = seen || m[k];
        end
        return r;
    endfunction

    // digits that come after the one-hot position
    function automatic logic [MAX_DIMS-1:0] after_mask(input logic [MAX_DIMS-1:0] oh);
        logic [MAX_DIMS-1:0] r;
        logic                acc;
        r   = '0;
        acc = 1'b0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            r[k] = acc;
            acc  = acc || oh[k];
        end
        return r;
    endfunction

    // num_dims above the digit count saturates
    always_comb
    begin
        if (int'(num_dims_reg) > MAX_DIMS)
        begin
            used = CNT_W'(MAX_DIMS);
        end
        else
        begin
            used = CNT_W'(num_dims_reg);
        end
    end

    assign have_dims = (used != '0);

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            dig[k]       = CALC_W'($signed(idx_reg[k]));
            ext[k]       = $signed({2'b00, ext_reg[k]});
            lim[k]       = ext[k] - calc_t'(1);
            used_mask[k] = CNT_W'(k) < used;
            last_mask[k] = CNT_W'(k) == (used - CNT_W'(1));
            can_inc[k]   = used_mask[k] && (dig[k] < lim[k]);
            can_dec[k]   = used_mask[k] && (dig[k] >= calc_t'(1));
        end
    end

    assign piv_inc = top_onehot(can_inc);
    assign piv_dec = top_onehot(can_dec);
    assign aft_inc = after_mask(piv_inc) & used_mask;
    assign aft_dec = after_mask(piv_dec) & used_mask;

    // incremented pivot digit, copied into the later digits by next nondecreasing
    always_comb
    begin
        piv_val = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (piv_inc[k])
            begin
                piv_val = piv_val | (dig[k] + calc_t'(1));
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            nxt[k] = dig[k];
            case (req_cmd_reg)
                CMD_LOAD:
                begin
                    nxt[k] = CALC_W'($signed(req_ld_reg[k]));
                end
                CMD_NEXT, CMD_NEXTND:
                begin
                    if (!have_dims)
                    begin
                        nxt[k] = dig[k];
                    end
                    else if (|can_inc)
                    begin
                        if (piv_inc[k])
                        begin
                            nxt[k] = dig[k] + calc_t'(1);
                        end
                        else if (aft_inc[k])
                        begin
                            nxt[k] = (req_cmd_reg == CMD_NEXT) ? calc_t'(0) : piv_val;
                        end
                    end
                    else if (used_mask[k])
                    begin
                        // past the end: maxima, last digit at its extent
                        nxt[k] = last_mask[k] ? ext[k] : lim[k];
                    end
                end
                CMD_PREV:
                begin
                    if (!have_dims)
                    begin
                        nxt[k] = dig[k];
                    end
                    else if (|can_dec)
                    begin
                        if (piv_dec[k])
                        begin
                            nxt[k] = dig[k] - calc_t'(1);
                        end
                        else if (aft_dec[k])
                        begin
                            nxt[k] = lim[k];
                        end
                    end
                    else if (used_mask[k])
                    begin
                        // before the start: zeros, last digit at minus one
                        nxt[k] = last_mask[k] ? calc_t'(-1) : calc_t'(0);
                    end
                end
                default:
                begin
                    // query and unassigned codes leave the index alone
                    nxt[k] = dig[k];
                end
            endcase
            idx_next[k] = nxt[k][DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        adv_next = 1'b0;
        case (req_cmd_reg)
            CMD_NEXT, CMD_NEXTND:
            begin
                adv_next = have_dims && (|can_inc);
            end
            CMD_PREV:
            begin
                adv_next = have_dims && (|can_dec);
            end
            default:
            begin
                adv_next = 1'b0;
            end
        endcase
    end

    // bounds checks on the new index
    always_comb
    begin
        ok_next     = 1'b1;
        ok_ext_next = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (used_mask[k])
            begin
                if (nxt[k] < calc_t'(0) || nxt[k] >= ext[k])
                begin
                    ok_next = 1'b0;
                end
            end
            else if (nxt[k] != calc_t'(0))
            begin
                ok_ext_next = 1'b0;
            end
        end
        ok_ext_next = ok_ext_next && ok_next;
    end

    // index state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (step_fire)
        begin
            idx_reg <= idx_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    digits_t out_idx_reg;
    logic    out_adv_reg;
    logic    out_ok_reg;
    logic    out_ok_ext_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_idx_reg    <= idx_next;
            out_adv_reg    <= adv_next;
            out_ok_reg     <= ok_next;
            out_ok_ext_reg <= ok_ext_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.advanced      = out_adv_reg;
    assign rsp.in_bounds     = out_ok_reg;
    assign rsp.in_bounds_ext = out_ok_ext_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            rsp.index[k] = out_idx_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the reported index is the index the block keeps
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> (out_idx_reg == idx_reg))
        else $error("result index differs from stored index");

    // load and query never report an advance
    a_no_adv_on_load_query: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && (req_cmd_reg == CMD_LOAD || req_cmd_reg == CMD_QUERY)
        |=> !out_adv_reg)
        else $error("advanced set for load or query");

    // with no dimensions in use only a load changes the index
    a_zero_dims_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && !have_dims && req_cmd_reg != CMD_LOAD
        |=> idx_reg == $past(idx_reg))
        else $error("index moved with zero dimensions");

    // a blocked request stays in the request register
    a_req_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !out_free |=> req_valid_reg && $stable(req_cmd_reg))
        else $error("blocked request lost");

endmodule : multidim_index_stepper

`default_nettype wire

>>> tb/sv/mis_tb_pkg.sv
// mis_tb_pkg: beat types and the index scoreboard for the stepper testbench
// the scoreboard predicts each response beat and checks it field by field
// depends on mis_pkg
`default_nettype none

package mis_tb_pkg;
    import mis_pkg::*;

    localparam int N_DIMS      = DEF_MAX_DIMS;
    localparam int EXTENT_BITS = DEF_EXTENT_BITS;
    localparam int DIGIT_W     = DEF_EXTENT_BITS + 1;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        digit_t [N_DIMS-1:0]       load_value;
    } request_t;

    typedef struct packed {
        digit_t [N_DIMS-1:0]       index;
        logic                      advanced;
        logic                      in_bounds;
        logic                      in_bounds_ext;
    } result_t;

    class index_scoreboard;
        int unsigned num_dims;
        int          extent [N_DIMS];
        int          digit [N_DIMS];
        result_t     expected_indexes [$];
        int unsigned error_count;
        int unsigned result_count;

        function new();
            num_dims = NUM_DIMS_RST;
            for (int k = 0; k < N_DIMS; k++)
            begin
                extent[k] = 1;
                digit[k]  = 0;
            end
            error_count  = 0;
            result_count = 0;
        endfunction

        function void write_register(int unsigned idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_NUM_DIMS)
                num_dims = value[NDIMS_W-1:0];
            else if (idx <= N_DIMS)
                extent[idx-1] = value[EXTENT_BITS-1:0];
        endfunction

        // odometer or nondecreasing step; returns 0 when it runs past the end
        function bit step_forward(int used, bit nondecreasing);
            for (int k = used - 1; k >= 0; k--)
            begin
                if (digit[k] < extent[k] - 1)
                begin
                    digit[k]++;
                    if (nondecreasing)
                        for (int j = k + 1; j < used; j++)
                            digit[j] = digit[k];
                    return 1'b1;
                end
                if (!nondecreasing)
                    digit[k] = 0;
            end
            for (int k = 0; k < used - 1; k++)
                digit[k] = extent[k] - 1;
            digit[used-1] = extent[used-1];
            return 1'b0;
        endfunction

        function bit step_backward(int used);
            for (int k = used - 1; k >= 0; k--)
            begin
                if (digit[k] >= 1)
                begin
                    digit[k]--;
                    return 1'b1;
                end
                digit[k] = extent[k] - 1;
            end
            for (int k = 0; k < used - 1; k++)
                digit[k] = 0;
            digit[used-1] = -1;
            return 1'b0;
        endfunction

        function void note_request(request_t r);
            int      used;
            bit      moved;
            result_t want;
            used  = (num_dims > N_DIMS) ? N_DIMS : int'(num_dims);
            moved = 1'b0;
            if (r.command == CMD_LOAD)
            begin
                for (int k = 0; k < N_DIMS; k++)
                    digit[k] = $signed(r.load_value[k]);
            end
            else if (used > 0)
            begin
                case (r.command)
                    CMD_NEXT:   moved = step_forward(used, 1'b0);
                    CMD_NEXTND: moved = step_forward(used, 1'b1);
                    CMD_PREV:   moved = step_backward(used);
                    default:    moved = 1'b0;
                endcase
            end
            want.in_bounds = 1'b1;
            for (int k = 0; k < used; k++)
                if (digit[k] < 0 || digit[k] >= extent[k])
                    want.in_bounds = 1'b0;
            want.in_bounds_ext = want.in_bounds;
            for (int k = used; k < N_DIMS; k++)
                if (digit[k] != 0)
                    want.in_bounds_ext = 1'b0;
            for (int k = 0; k < N_DIMS; k++)
                want.index[k] = digit[k][DIGIT_W-1:0];
            want.advanced = moved;
            expected_indexes.push_back(want);
        endfunction

        task report(string msg);
            $display("mismatch at response beat %0d: %s", result_count, msg);
            error_count++;
        endtask

        task check_result(result_t got);
            result_t want;
            result_count++;
            if (expected_indexes.size() == 0)
            begin
                report("response beat with nothing expected");
                return;
            end
            want = expected_indexes.pop_front();
            for (int k = 0; k < N_DIMS; k++)
                if (got.index[k] !== want.index[k])
                    report($sformatf("index_%0d got %0d expected %0d", k,
                                     $signed(got.index[k]), $signed(want.index[k])));
            if (got.advanced !== want.advanced)
                report($sformatf("advanced got %b expected %b", got.advanced, want.advanced));
            if (got.in_bounds !== want.in_bounds)
                report($sformatf("in_bounds got %b expected %b",
                                 got.in_bounds, want.in_bounds));
            if (got.in_bounds_ext !== want.in_bounds_ext)
                report($sformatf("in_bounds_ext got %b expected %b",
                                 got.in_bounds_ext, want.in_bounds_ext));
        endtask

        function int pending();
            return expected_indexes.size();
        endfunction
    endclass

endpackage : mis_tb_pkg

`default_nettype wire

>>> tb/sv/multidim_index_stepper_tb.sv
// multidim_index_stepper_tb: drives commands through the request channel, checks
// every response beat against the index scoreboard, reprograms the apb registers
// depends on mis_pkg, mis_req_if, mis_rsp_if, mis_tb_pkg and the stepper rtl
`default_nettype none

module multidim_index_stepper_tb;
    import mis_pkg::*;
    import mis_tb_pkg::*;

    localparam int ADDR_W        = $clog2((N_DIMS + 1) * 4);
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_BEATS = 66;
    // the request and result registers of the pipe plus margin
    localparam int DRAIN_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mis_req_if req_if ();
    mis_rsp_if rsp_if ();

    index_scoreboard sb = new();

    // idle odds in percent per cycle, changed per phase of the run
    int unsigned tx_idle_pct = 24;
    int unsigned rx_idle_pct = 81;
    int unsigned cycle_count = 0;

    // register values last written, used to aim load digits
    int unsigned cfg_dims = NUM_DIMS_RST;
    int          cfg_extent [N_DIMS] = '{default: 1};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multidim_index_stepper u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    // run limit, generous against the slowest legal run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[multidim_index_stepper] ERROR");
        $finish;
    end

    // response side: sample the beat at the edge, then pick ready for next cycle
    initial
    begin
        result_t beat;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                for (int k = 0; k < N_DIMS; k++)
                    beat.index[k] = rsp_if.index[k];
                beat.advanced      = rsp_if.advanced;
                beat.in_bounds     = rsp_if.in_bounds;
                beat.in_bounds_ext = rsp_if.in_bounds_ext;
                sb.check_result(beat);
            end
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // one request beat; valid stays up across back-to-back beats
    task automatic send_beat(request_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.command <= r.command;
        for (int k = 0; k < N_DIMS; k++)
            req_if.load_value[k] <= r.load_value[k];
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        sb.note_request(r);
    endtask

    // stop sending and let every expected beat come back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // setup then access phase; psel stays up so writes can run back to back
    task automatic write_reg(int unsigned idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        sb.write_register(idx, value);
    endtask

    // full register set; upper data bits are random and must be ignored
    task automatic configure(int unsigned dims, int e0, int e1, int e2, int e3);
        int                    ext [N_DIMS];
        logic [APB_DATA_W-1:0] value;
        ext = '{e0, e1, e2, e3};
        drain();
        cfg_dims = dims;
        value = $urandom();
        value[NDIMS_W-1:0] = NDIMS_W'(dims);
        write_reg(REG_NUM_DIMS, value);
        for (int k = 0; k < N_DIMS; k++)
        begin
            cfg_extent[k] = ext[k];
            value = $urandom();
            value[EXTENT_BITS-1:0] = EXTENT_BITS'(ext[k]);
            write_reg(REG_NUM_DIMS + 1 + k, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // step or query beat; load digits are noise the block must ignore
    function automatic request_t plain_cmd(logic [CMD_W-1:0] c);
        request_t r;
        r.command = c;
        for (int k = 0; k < N_DIMS; k++)
            r.load_value[k] = DIGIT_W'($urandom());
        return r;
    endfunction

    function automatic request_t load_of(int v0, int v1, int v2, int v3);
        request_t r;
        r.command       = CMD_LOAD;
        r.load_value[0] = DIGIT_W'(v0);
        r.load_value[1] = DIGIT_W'(v1);
        r.load_value[2] = DIGIT_W'(v2);
        r.load_value[3] = DIGIT_W'(v3);
        return r;
    endfunction

    // mostly in range so the steps walk real combinations; edges and junk otherwise
    function automatic digit_t random_digit(int k);
        int unsigned sel;
        int unsigned used;
        sel  = $urandom_range(99);
        used = (cfg_dims > N_DIMS) ? N_DIMS : cfg_dims;
        if (k >= used && sel < 70)
            return '0;
        if (sel < 75 && cfg_extent[k] > 0)
            return DIGIT_W'($urandom_range(cfg_extent[k] - 1, 0));
        if (sel < 85)
            return DIGIT_W'(cfg_extent[k] - int'($urandom_range(1, 0)));
        if (sel < 92)
            return '1;
        return DIGIT_W'($urandom());
    endfunction

    function automatic request_t random_request();
        request_t    r;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            r.command = CMD_LOAD;
            for (int k = 0; k < N_DIMS; k++)
                r.load_value[k] = random_digit(k);
        end
        else if (sel < 42)
            r = plain_cmd(CMD_NEXT);
        else if (sel < 62)
            r = plain_cmd(CMD_NEXTND);
        else if (sel < 87)
            r = plain_cmd(CMD_PREV);
        else if (sel < 93)
            r = plain_cmd(CMD_QUERY);
        else
            r = plain_cmd(CMD_W'($urandom_range(2 ** CMD_W - 1, CMD_QUERY + 1)));
        return r;
    endfunction

    // small extents mostly so carries and wraps happen often
    function automatic int pick_extent();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(5, 1);
        if (sel < 80)
            return $urandom_range(300, 6);
        if (sel < 87)
            return 0;
        if (sel < 94)
            return 2 ** EXTENT_BITS - 1;
        return $urandom_range(2 ** EXTENT_BITS - 1, 0);
    endfunction

    function automatic int unsigned pick_dims();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 75)
            return $urandom_range(N_DIMS, 1);
        if (sel < 85)
            return N_DIMS;
        if (sel < 92)
            return 0;
        return $urandom_range(2 ** NDIMS_W - 1, N_DIMS + 1);
    endfunction

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        req_if.valid   <= 1'b0;
        req_if.command <= CMD_QUERY;
        for (int k = 0; k < N_DIMS; k++)
            req_if.load_value[k] <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one dimension of extent one
        send_beat(plain_cmd(CMD_QUERY));
        send_beat(plain_cmd(CMD_NEXT));          // past the end, digit at its extent
        send_beat(plain_cmd(CMD_PREV));          // back into range
        send_beat(plain_cmd(CMD_PREV));          // before the first, digit at -1
        send_beat(plain_cmd(CMD_NEXTND));        // from -1 back to zero
        // unused digits nonzero, sign bit and top value in the load
        send_beat(load_of(-1, 2 ** EXTENT_BITS - 1, -(2 ** EXTENT_BITS), 1));
        send_beat(plain_cmd(CMD_W'(2 ** CMD_W - 1)));
        send_beat(plain_cmd(CMD_W'(CMD_QUERY + 1)));

        // all four dimensions, one of them at full extent
        configure(N_DIMS, 2, 3, 1, 2 ** EXTENT_BITS - 1);
        send_beat(load_of(1, 2, 0, 2 ** EXTENT_BITS - 3));
        send_beat(plain_cmd(CMD_NEXT));
        send_beat(plain_cmd(CMD_NEXT));          // carry through every digit, past the end
        send_beat(plain_cmd(CMD_PREV));
        send_beat(load_of(0, 1, 0, 2 ** EXTENT_BITS - 2));
        send_beat(plain_cmd(CMD_NEXTND));        // later digits copy, full ones not cleared
        send_beat(load_of(0, 0, 0, 0));
        send_beat(plain_cmd(CMD_PREV));          // borrow through every digit, before first
        send_beat(plain_cmd(CMD_QUERY));

        // zero dimensions: steps leave the index alone
        configure(0, 0, 0, 0, 0);
        send_beat(plain_cmd(CMD_NEXT));
        send_beat(plain_cmd(CMD_PREV));
        send_beat(load_of(3, 0, 0, 0));

        // too many dimensions counts as all, zero-size dimension
        configure(2 ** NDIMS_W - 1, 0, 2 ** EXTENT_BITS - 1, 1, 3);
        send_beat(load_of(0, 0, 0, 0));
        send_beat(plain_cmd(CMD_NEXT));
        send_beat(load_of(-1, 2 ** EXTENT_BITS - 1, 0, 2));
        send_beat(plain_cmd(CMD_NEXT));
        send_beat(plain_cmd(CMD_NEXTND));
        send_beat(plain_cmd(CMD_PREV));

        // random segments, each with fresh registers; idle pattern per third
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS / 3)
            begin
                tx_idle_pct = 81;
                rx_idle_pct = 24;
            end
            else if (seg == 2 * SEGMENTS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            configure(pick_dims(), pick_extent(), pick_extent(), pick_extent(), pick_extent());
            for (int i = 0; i < SEGMENT_BEATS; i++)
                send_beat(random_request());
        end

        drain();
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("[multidim_index_stepper] OK");
        else
            $display("[multidim_index_stepper] ERROR");
        $finish;
    end

endmodule : multidim_index_stepper_tb

`default_nettype wire

>>> sim.f
hw/rtl/mis_pkg.sv
hw/rtl/mis_if.sv
hw/rtl/multidim_index_stepper.sv
tb/sv/mis_tb_pkg.sv
tb/sv/multidim_index_stepper_tb.sv
